FILE: sv/offset_moving_average_tracker_top_assert.svh
// assertion macros used by the port checker
`ifndef OFFSET_MOVING_AVERAGE_TRACKER_TOP_ASSERT_SVH
`define OFFSET_MOVING_AVERAGE_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define OMAT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("omat port check failed");

// next-cycle implication, disabled while reset is high
`define OMAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("omat port check failed");

`endif

FILE: sv/omat_pkg.sv
// shared widths, register indexes and control types of the offset moving average tracker
`timescale 1ns / 1ps
`default_nettype none

package omat_pkg;

   // field and state widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int ENTRY_W      = SAMPLE_WIDTH + 1;
   localparam int TOTAL_W      = 24;
   localparam int SUM_W        = SAMPLE_WIDTH + 9;
   localparam int COUNT_W      = 9;
   localparam int WLEN_W       = 7;
   localparam int OSAMP_W      = 8;
   localparam int DIVISOR_W    = 8;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_SAMPLES = 1'b1;
   localparam logic [WLEN_W-1:0]      WINDOW_LENGTH_RESET = 7'd8;

   // default ring depth
   localparam int DEFAULT_WINDOW_DEPTH = 64;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic rd_en;
      logic rd_prev;
      logic accept;
      logic calib_add;
      logic div_start;
      logic div_sel_avg;
      logic set_offset;
      logic upd_total;
      logic upd_avg;
      logic upd_accel;
      logic load_rsp;
   } omat_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic is_calib;
      logic need_div;
      logic div_done;
   } omat_status_type;

endpackage

`default_nettype wire

FILE: sv/omat_channel_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface omat_req_if;
   import omat_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface omat_rsp_if;
   import omat_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           calibrating;
   logic signed [SAMPLE_WIDTH-1:0] offset;
   logic signed [ENTRY_W-1:0]      average;
   logic signed [TOTAL_W-1:0]      accel;
   logic signed [ENTRY_W-1:0]      minimum;
   logic signed [ENTRY_W-1:0]      maximum;
   logic                           window_wrapped;

   modport source (output valid, output calibrating, output offset, output average,
                   output accel, output minimum, output maximum, output window_wrapped,
                   input ready);
   modport sink   (input valid, input calibrating, input offset, input average,
                   input accel, input minimum, input maximum, input window_wrapped,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/omat_div.sv
// restoring divider: signed dividend by unsigned divisor, quotient truncated toward zero
`timescale 1ns / 1ps
`default_nettype none

module omat_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [omat_pkg::SUM_W-1:0]   dividend,
   input  wire logic [omat_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                     done,
   output logic signed [omat_pkg::SUM_W-1:0]        quotient
);
   import omat_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(SUM_W)) begin
            // apply the sign after the last step
            quo_in  = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = fits ? DIVISOR_W'(trial - {1'b0, den_ff}) : trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = $signed(quo_ff);

endmodule

`default_nettype wire

FILE: sv/omat_datapath.sv
// datapath: configuration, calibration, rings, running totals, min/max and result register
`timescale 1ns / 1ps
`default_nettype none

module omat_datapath #(
   parameter int WINDOW_DEPTH = omat_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire omat_pkg::omat_cmd_type                 cmd,
   output omat_pkg::omat_status_type                   status,
   input  wire logic                                   csr_write,
   input  wire logic [omat_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [omat_pkg::CSR_DATA_W-1:0]        csr_data,
   input  wire logic signed [omat_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                        rsp_calibrating,
   output logic signed [omat_pkg::SAMPLE_WIDTH-1:0]    rsp_offset,
   output logic signed [omat_pkg::ENTRY_W-1:0]         rsp_average,
   output logic signed [omat_pkg::TOTAL_W-1:0]         rsp_accel,
   output logic signed [omat_pkg::ENTRY_W-1:0]         rsp_minimum,
   output logic signed [omat_pkg::ENTRY_W-1:0]         rsp_maximum,
   output logic                                        rsp_window_wrapped
);
   import omat_pkg::*;

   localparam int POS_W = $clog2(WINDOW_DEPTH);

   // configuration registers
   logic [WLEN_W-1:0]  wlen_ff;
   logic [OSAMP_W-1:0] osamp_ff;

   // model state
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           clr_ff;
   logic signed [TOTAL_W-1:0]  rt_ff, rt_in;
   logic signed [TOTAL_W-1:0]  at_ff, at_in;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_WIDTH-1:0] offset_ff;
   logic signed [ENTRY_W-1:0]  min_ff, max_ff;

   // per-word working registers
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [TOTAL_W-1:0]  rtv_ff;
   logic signed [ENTRY_W-1:0]  rr_rd_ff, ar_rd_ff;
   logic signed [ENTRY_W-1:0]  old_avg_ff, avg_ff;
   logic                       res_calib_ff, res_wrap_ff;
   logic signed [ENTRY_W-1:0]  res_avg_ff;
   logic signed [TOTAL_W-1:0]  res_accel_ff;

   // response register
   logic                       rsp_calib_ff, rsp_wrap_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_offset_ff;
   logic signed [ENTRY_W-1:0]  rsp_avg_ff, rsp_min_ff, rsp_max_ff;
   logic signed [TOTAL_W-1:0]  rsp_accel_ff;

   // rings
   logic signed [ENTRY_W-1:0]  rr_mem [WINDOW_DEPTH];
   logic signed [ENTRY_W-1:0]  ar_mem [WINDOW_DEPTH];

   logic [WLEN_W-1:0]          len;
   logic [POS_W-1:0]           prev;
   logic [POS_W-1:0]           ar_raddr;
   logic [POS_W:0]             pos_inc;
   logic                       wrap;
   logic signed [ENTRY_W-1:0]  v;
   logic signed [ENTRY_W-1:0]  avg_new;
   logic signed [ENTRY_W-1:0]  ar_prev;
   logic signed [TOTAL_W-1:0]  accel;
   logic signed [SUM_W-1:0]    div_dividend;
   logic [DIVISOR_W-1:0]       div_divisor;
   logic                       div_done;
   logic signed [SUM_W-1:0]    div_quotient;

   // effective window length, clamped to 1..WINDOW_DEPTH
   always_comb begin
      if (wlen_ff == '0) begin
         len = WLEN_W'(1);
      end else if (32'(wlen_ff) > WINDOW_DEPTH) begin
         len = WLEN_W'(WINDOW_DEPTH);
      end else begin
         len = wlen_ff;
      end
   end

   // ring positions
   always_comb begin
      if (pos_ff == '0) begin
         prev = POS_W'(len - WLEN_W'(1));
      end else begin
         prev = pos_ff - POS_W'(1);
      end
   end
   assign pos_inc  = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign wrap     = 32'(pos_inc) >= 32'(len);
   assign pos_in   = wrap ? '0 : pos_inc[POS_W-1:0];
   assign ar_raddr = cmd.rd_prev ? prev : pos_ff;

   // offset-corrected reading and running totals
   assign v       = ENTRY_W'(sample_ff) - ENTRY_W'(offset_ff);
   assign rt_in   = rt_ff - TOTAL_W'(rr_rd_ff) + TOTAL_W'(v);
   assign avg_new = $signed(div_quotient[ENTRY_W-1:0]);
   assign at_in   = at_ff - TOTAL_W'(old_avg_ff) + TOTAL_W'(avg_new);
   // with a one-entry window the previous slot is the one just written
   assign ar_prev = (prev == pos_ff) ? avg_ff : ar_rd_ff;
   assign accel   = rtv_ff - at_ff + TOTAL_W'(ar_prev);

   // status to controller
   assign status.clear_last = clr_ff == POS_W'(WINDOW_DEPTH - 1);
   assign status.is_calib   = COUNT_W'(osamp_ff) >= count_ff;
   assign status.need_div   = (count_ff == COUNT_W'(osamp_ff)) && (osamp_ff != '0);
   assign status.div_done   = div_done;

   // shared divider operands
   assign div_dividend = cmd.div_sel_avg ? SUM_W'(rt_ff) : sum_ff;
   assign div_divisor  = cmd.div_sel_avg ? DIVISOR_W'(len) : osamp_ff;

   omat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= WINDOW_LENGTH_RESET;
         osamp_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:  wlen_ff  <= csr_data[WLEN_W-1:0];
            CSR_OFFSET_SAMPLES: osamp_ff <= csr_data[OSAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         clr_ff    <= '0;
         rt_ff     <= '0;
         at_ff     <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         offset_ff <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + POS_W'(1);
         end
         if (cmd.calib_add) begin
            if (count_ff < COUNT_W'(osamp_ff)) begin
               sum_ff <= sum_ff + SUM_W'(sample_ff);
            end else begin
               offset_ff <= '0;
            end
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.set_offset) begin
            offset_ff <= div_quotient[SAMPLE_WIDTH-1:0];
            count_ff  <= count_ff + COUNT_W'(1);
         end
         if (cmd.upd_total) begin
            rt_ff <= rt_in;
            if (v < min_ff) begin
               min_ff <= v;
            end
            if (v > max_ff) begin
               max_ff <= v;
            end
         end
         if (cmd.upd_avg) begin
            at_ff <= at_in;
         end
         if (cmd.upd_accel) begin
            pos_ff <= pos_in;
         end
      end
   end

   // per-word working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.upd_total) begin
         rtv_ff     <= rt_ff - TOTAL_W'(rr_rd_ff);
         old_avg_ff <= ar_rd_ff;
      end
      if (cmd.upd_avg) begin
         avg_ff <= avg_new;
      end
      if (cmd.calib_add || cmd.set_offset) begin
         res_calib_ff <= 1'b1;
         res_avg_ff   <= '0;
         res_accel_ff <= '0;
         res_wrap_ff  <= 1'b0;
      end
      if (cmd.upd_accel) begin
         res_calib_ff <= 1'b0;
         res_avg_ff   <= avg_ff;
         res_accel_ff <= accel;
         res_wrap_ff  <= wrap;
      end
   end

   // ring writes: clearing pass, new reading, new average
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         rr_mem[clr_ff] <= '0;
         ar_mem[clr_ff] <= '0;
      end else begin
         if (cmd.upd_total) begin
            rr_mem[pos_ff] <= v;
         end
         if (cmd.upd_avg) begin
            ar_mem[pos_ff] <= avg_new;
         end
      end
   end

   // registered ring reads
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rr_rd_ff <= rr_mem[pos_ff];
         ar_rd_ff <= ar_mem[ar_raddr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_calib_ff  <= res_calib_ff;
         rsp_offset_ff <= offset_ff;
         rsp_avg_ff    <= res_avg_ff;
         rsp_accel_ff  <= res_accel_ff;
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_wrap_ff   <= res_wrap_ff;
      end
   end

   assign rsp_calibrating    = rsp_calib_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_average        = rsp_avg_ff;
   assign rsp_accel          = rsp_accel_ff;
   assign rsp_minimum        = rsp_min_ff;
   assign rsp_maximum        = rsp_max_ff;
   assign rsp_window_wrapped = rsp_wrap_ff;

endmodule

`default_nettype wire

FILE: sv/omat_ctrl.sv
// controller: sequences the clearing pass, calibration and filter steps of each word
`timescale 1ns / 1ps
`default_nettype none

module omat_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire omat_pkg::omat_status_type  status,
   output omat_pkg::omat_cmd_type          cmd,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready
);
   import omat_pkg::*;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_IDLE   = 10'b00_0000_0010,
      ST_CALIB  = 10'b00_0000_0100,
      ST_CSTART = 10'b00_0000_1000,
      ST_CWAIT  = 10'b00_0001_0000,
      ST_TOTAL  = 10'b00_0010_0000,
      ST_ASTART = 10'b00_0100_0000,
      ST_AWAIT  = 10'b00_1000_0000,
      ST_ACCEL  = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } omat_state_type;

   omat_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.rd_en = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!status.is_calib) begin
                  state_in = ST_TOTAL;
               end else if (status.need_div) begin
                  state_in = ST_CSTART;
               end else begin
                  state_in = ST_CALIB;
               end
            end
         end
         ST_CALIB: begin
            cmd.calib_add = 1'b1;
            state_in      = ST_DONE;
         end
         ST_CSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (status.div_done) begin
               cmd.set_offset = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_TOTAL: begin
            cmd.upd_total = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_prev   = 1'b1;
            state_in      = ST_ASTART;
         end
         ST_ASTART: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_avg = 1'b1;
            state_in        = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (status.div_done) begin
               cmd.upd_avg = 1'b1;
               state_in    = ST_ACCEL;
            end
         end
         ST_ACCEL: begin
            cmd.upd_accel = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: sv/offset_moving_average_tracker_top.sv
// Offset moving average tracker, top level.
// A plain calibration word skips the 25-step restoring divider; the word that sets the
// offset and each filtered word wait for it.
// Words are taken one at a time; the next is accepted no sooner than the cycle after the result loads.
// Reset (synchronous): clears the control, configuration and tracker state, then a
// clearing pass zeroes both rings while no word is accepted; configuration writes are taken in the pass.
`timescale 1ns / 1ps
`default_nettype none

module offset_moving_average_tracker_top #(
   parameter int WINDOW_DEPTH = omat_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   omat_req_if.sink                              req_bus,
   omat_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_write,
   input  wire logic [omat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [omat_pkg::CSR_DATA_W-1:0]  csr_data
);
   import omat_pkg::*;

   omat_cmd_type    cmd;
   omat_status_type status;

   // sequencing
   omat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready)
   );

   // arithmetic and storage
   omat_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_sample         (req_bus.sample),
      .rsp_calibrating    (rsp_bus.calibrating),
      .rsp_offset         (rsp_bus.offset),
      .rsp_average        (rsp_bus.average),
      .rsp_accel          (rsp_bus.accel),
      .rsp_minimum        (rsp_bus.minimum),
      .rsp_maximum        (rsp_bus.maximum),
      .rsp_window_wrapped (rsp_bus.window_wrapped)
   );

endmodule

`default_nettype wire

FILE: sv/omat_checker.sv
// port-level checker for the tracker and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "offset_moving_average_tracker_top_assert.svh"

module omat_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   omat_req_if.sink   req_bus,
   omat_rsp_if.source rsp_bus
);

   // a waiting result stays valid and keeps its average and accel
   `OMAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_bus.average) && $stable(rsp_bus.accel))

   // one word in flight: ready drops after an accept
   `OMAT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)

   // calibration results carry no filter output
   `OMAT_ASSERT_NOW(a_calib_clean, clock, reset, rsp_bus.valid && rsp_bus.calibrating, rsp_bus.average == 0 && rsp_bus.accel == 0 && !rsp_bus.window_wrapped)

   // min and max start at zero, so they bracket it
   `OMAT_ASSERT_NOW(a_min_max, clock, reset, rsp_bus.valid, rsp_bus.minimum <= 0 && rsp_bus.maximum >= 0)

   // no result straight out of reset
   `OMAT_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_bus.valid)

endmodule

bind offset_moving_average_tracker_top omat_checker u_omat_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

`default_nettype wire

FILE: bench/tb_top.sv
// sample stream test of the offset moving average tracker with per-word result checks
`timescale 1ns / 1ps

module tb_top;
   import omat_pkg::*;

   localparam int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH;
   localparam int WORD_TARGET  = 1450;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 40;
   localparam int MAX_REPORTS  = 10;

   // one result word as the block presents it
   typedef struct packed {
      logic                           calibrating;
      logic signed [SAMPLE_WIDTH-1:0] offset;
      logic signed [ENTRY_W-1:0]      average;
      logic signed [TOTAL_W-1:0]      accel;
      logic signed [ENTRY_W-1:0]      minimum;
      logic signed [ENTRY_W-1:0]      maximum;
      logic                           window_wrapped;
   } tracker_word_t;

   logic clock;
   logic reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   omat_req_if req_bus ();
   omat_rsp_if rsp_bus ();

   offset_moving_average_tracker_top #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // tracker state as the bench sees it
   logic signed [ENTRY_W-1:0]      reading_hist [WINDOW_DEPTH];
   logic signed [ENTRY_W-1:0]      average_hist [WINDOW_DEPTH];
   int                             write_slot;
   logic signed [TOTAL_W-1:0]      reading_sum;
   logic signed [TOTAL_W-1:0]      average_sum;
   int                             calib_seen;
   logic signed [SUM_W-1:0]        calib_acc;
   logic signed [SAMPLE_WIDTH-1:0] offset_now;
   logic signed [ENTRY_W-1:0]      low_mark;
   logic signed [ENTRY_W-1:0]      high_mark;
   logic [WLEN_W-1:0]              cfg_window;
   logic [OSAMP_W-1:0]             cfg_osamp;

   tracker_word_t pending_words [$];

   // run bookkeeping
   int  words_sent      = 0;
   int  results_checked = 0;
   int  calib_results   = 0;
   int  wrap_results    = 0;
   int  settings_count  = 0;
   int  error_count     = 0;
   int  quiet_cycles    = 0;
   int  rsp_hold_cycles = 0;
   bit  req_idle_on     = 1'b1;
   bit  rsp_idle_on     = 1'b1;

   // next result word for one accepted sample, updating the tracked state
   function automatic tracker_word_t track_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
      tracker_word_t             r;
      int                        len;
      int                        slot;
      int                        prev_slot;
      longint                    divisor;
      longint                    quotient;
      logic signed [ENTRY_W-1:0] corrected;
      logic signed [ENTRY_W-1:0] avg;
      r = '0;
      len = int'(cfg_window);
      if (len == 0) begin
         len = 1;
      end else if (len > WINDOW_DEPTH) begin
         len = WINDOW_DEPTH;
      end
      // calibration: sum the first samples, the next one fixes the offset
      if (calib_seen <= int'(cfg_osamp)) begin
         if (calib_seen < int'(cfg_osamp)) begin
            calib_acc = calib_acc + SUM_W'(smp);
         end else if (cfg_osamp == 0) begin
            offset_now = '0;
         end else begin
            divisor = longint'(cfg_osamp);
            quotient = longint'(calib_acc) / divisor;
            offset_now = quotient[SAMPLE_WIDTH-1:0];
         end
         calib_seen++;
         r.calibrating = 1'b1;
         r.offset      = offset_now;
         r.minimum     = low_mark;
         r.maximum     = high_mark;
         return r;
      end
      // filtered sample into the reading ring
      slot = write_slot % WINDOW_DEPTH;
      corrected = ENTRY_W'(smp) - ENTRY_W'(offset_now);
      reading_sum = reading_sum - TOTAL_W'(reading_hist[slot]) + TOTAL_W'(corrected);
      reading_hist[slot] = corrected;
      if (corrected < low_mark) begin
         low_mark = corrected;
      end
      if (corrected > high_mark) begin
         high_mark = corrected;
      end
      // truncating average into its own ring
      quotient = longint'(reading_sum) / longint'(len);
      avg = quotient[ENTRY_W-1:0];
      average_sum = average_sum - TOTAL_W'(average_hist[slot]) + TOTAL_W'(avg);
      average_hist[slot] = avg;
      prev_slot = (slot == 0) ? len - 1 : slot - 1;
      r.accel = (reading_sum - TOTAL_W'(corrected))
                - (average_sum - TOTAL_W'(average_hist[prev_slot]));
      // advance write position, wrapping at the window length
      slot++;
      if (slot >= len) begin
         slot = 0;
         r.window_wrapped = 1'b1;
      end
      write_slot  = slot;
      r.offset    = offset_now;
      r.average   = avg;
      r.minimum   = low_mark;
      r.maximum   = high_mark;
      return r;
   endfunction

   // mixture of extremes, small values and full-range values
   function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample();
      int v;
      v = 0;
      case ($urandom_range(0, 9))
         0: begin
            v = 32767;
         end
         1: begin
            v = -32768;
         end
         2, 3: begin
            v = $urandom_range(0, 400);
            v = v - 200;
         end
         default: begin
            v = $urandom();
         end
      endcase
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   // offer one sample word and log its expected result once taken
   task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] smp);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= smp;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      pending_words.push_back(track_sample(smp));
      words_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // write both registers back to back while the block is idle
   task automatic set_config(input logic [CSR_DATA_W-1:0] window_data,
                             input logic [CSR_DATA_W-1:0] osamp_data);
      csr_write <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_data  <= window_data;
      @(posedge clock);
      csr_index <= CSR_OFFSET_SAMPLES;
      csr_data  <= osamp_data;
      @(posedge clock);
      csr_write  <= 1'b0;
      cfg_window = window_data[WLEN_W-1:0];
      cfg_osamp  = osamp_data;
      settings_count++;
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                input logic signed [31:0] got_v);
      if (got_v !== exp_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: result %0d field %s expected %0d got %0d",
                     $time, results_checked, name, exp_v, got_v);
         end
      end
   endtask

   // default registers: first word calibrates with a zero offset, window of 8
   task automatic test_reset_defaults();
      send_word(-16'sd32768);
      send_word(16'sd32767);
      send_word(-16'sd32768);
      send_word(16'sd0);
      send_word(-16'sd1);
      send_word(16'sd1);
   endtask

   // raising the sample count later resumes calibration on the existing sum
   task automatic test_calibration_resume();
      wait_results_drained();
      set_config(8'd8, 8'd3);
      send_word(16'sd32767);
      send_word(16'sd32767);
      send_word(16'sd5);
      send_word(-16'sd32768);
   endtask

   // window of one, full depth, shrink below the write position, zero and oversize
   task automatic test_window_lengths();
      wait_results_drained();
      set_config(8'd1, 8'd3);
      send_word(16'sd32767);
      send_word(-16'sd32768);
      wait_results_drained();
      set_config(8'd64, 8'd3);
      repeat (7) send_word(draw_sample());
      wait_results_drained();
      set_config(8'd3, 8'd3);
      repeat (2) send_word(draw_sample());
      wait_results_drained();
      set_config(8'd0, 8'd0);
      repeat (2) send_word(draw_sample());
      wait_results_drained();
      set_config(8'hFF, 8'd0);
      repeat (2) send_word(draw_sample());
   endtask

   // long receiver hold-off with the sender pushing, then a sender pause
   task automatic test_backpressure();
      wait_results_drained();
      req_idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (12) send_word(draw_sample());
      wait_results_drained();
      req_idle_on = 1'b1;
      repeat (4) send_word(draw_sample());
   endtask

   // random phases, each with its own register settings and idling mix
   task automatic test_random_phases();
      int phase;
      int n;
      int raised;
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] odata;
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         wait_results_drained();
         case ($urandom_range(0, 7))
            0: wdata = 8'd0;
            1: wdata = 8'd1;
            2: wdata = 8'd64;
            3: wdata = CSR_DATA_W'($urandom_range(65, 255));
            4: wdata = CSR_DATA_W'($urandom_range(1, 64));
            default: wdata = CSR_DATA_W'($urandom_range(2, 12));
         endcase
         odata = cfg_osamp;
         if (phase == 6) begin
            odata = 8'd255;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  raised = calib_seen + $urandom_range(0, 4);
                  odata = (raised > 255) ? 8'd255 : raised[CSR_DATA_W-1:0];
               end
               1: odata = 8'd0;
               default: odata = cfg_osamp;
            endcase
         end
         set_config(wdata, odata);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 6 && calib_seen < 256) begin
            n = 256 - calib_seen + $urandom_range(20, 60);
         end else begin
            n = $urandom_range(15, 90);
         end
         repeat (n) send_word(draw_sample());
         phase++;
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // response ready with random stalls and one long hold
   initial begin : drive_rsp_ready
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 13) : 0;
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) @(posedge clock);
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : check_results
      tracker_word_t got_word;
      tracker_word_t exp_word;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got_word.calibrating    = rsp_bus.calibrating;
         got_word.offset         = rsp_bus.offset;
         got_word.average        = rsp_bus.average;
         got_word.accel          = rsp_bus.accel;
         got_word.minimum        = rsp_bus.minimum;
         got_word.maximum        = rsp_bus.maximum;
         got_word.window_wrapped = rsp_bus.window_wrapped;
         if (pending_words.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: result word with no sample outstanding", $time);
            end
         end else begin
            exp_word = pending_words.pop_front();
            results_checked++;
            if (exp_word.calibrating) begin
               calib_results++;
            end
            if (exp_word.window_wrapped) begin
               wrap_results++;
            end
            compare_field("calibrating", 32'(exp_word.calibrating),
                          32'(got_word.calibrating));
            compare_field("offset", 32'(exp_word.offset), 32'(got_word.offset));
            compare_field("average", 32'(exp_word.average), 32'(got_word.average));
            compare_field("accel", 32'(exp_word.accel), 32'(got_word.accel));
            compare_field("minimum", 32'(exp_word.minimum), 32'(got_word.minimum));
            compare_field("maximum", 32'(exp_word.maximum), 32'(got_word.maximum));
            compare_field("window_wrapped", 32'(exp_word.window_wrapped),
                          32'(got_word.window_wrapped));
         end
      end
   end

   // give up when neither channel moves for too long
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // reset, test sequence and final verdict
   initial begin : run_tests
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_write      <= 1'b0;
      csr_index      <= CSR_WINDOW_LENGTH;
      csr_data       <= '0;
      reset          <= 1'b1;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         reading_hist[i] = '0;
         average_hist[i] = '0;
      end
      write_slot  = 0;
      reading_sum = '0;
      average_sum = '0;
      calib_seen  = 0;
      calib_acc   = '0;
      offset_now  = '0;
      low_mark    = '0;
      high_mark   = '0;
      cfg_window  = WINDOW_LENGTH_RESET;
      cfg_osamp   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_calibration_resume();
      test_window_lengths();
      test_backpressure();
      test_random_phases();

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", pending_words.size());
      end
      $display("Sent %0d sample words over %0d register settings: %0d calibrating, %0d wraps",
               words_sent, settings_count, calib_results, wrap_results);
      $display("Checked %0d result words, %0d errors", results_checked, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/omat_pkg.sv
sv/omat_channel_if.sv
sv/omat_div.sv
sv/omat_datapath.sv
sv/omat_ctrl.sv
sv/offset_moving_average_tracker_top.sv
sv/omat_checker.sv
bench/tb_top.sv
